FILE: hdl/lrd_pkg.sv
// Shared types and constants for the multistate pattern text decoder.
// Used by the front end, back end, top level and checker; depends on nothing.
package lrd_pkg;

    typedef enum logic [1:0] {
        OP_BEGIN = 2'd0,
        OP_CHAR  = 2'd1,
        OP_END   = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] ch;
    } t_in;

    typedef struct packed {
        logic [31:0] cell_x;
        logic [31:0] cell_y;
        logic [23:0] run_length;
        logic [7:0]  cell_state;
    } t_out;

    typedef struct packed {
        logic [31:0] origin_x;
        logic [31:0] origin_y;
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [8:0]  state_modulus;
    } t_cfg;

    typedef enum logic [2:0] {
        CMD_HOME    = 3'd0,
        CMD_NEWLINE = 3'd1,
        CMD_SKIP    = 3'd2,
        CMD_RUN     = 3'd3,
        CMD_LETTER  = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [8:0] val;
    } t_cmd;

    localparam int CMD_BITS = $bits(t_cmd);

    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_START_X  = 3'd2;
    localparam logic [2:0] CFG_START_Y  = 3'd3;
    localparam logic [2:0] CFG_MODULUS  = 3'd4;

    localparam logic [8:0] MODULUS_RESET = 9'd2;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_P      = 8'h70;
    localparam logic [7:0] CH_Y      = 8'h79;

    localparam logic [7:0] PREFIX_STEP = 8'd24;
    localparam logic [8:0] LETTER_BASE = 9'd64;
    localparam logic [3:0] RADIX       = 4'd10;
    localparam logic [31:0] RUN_MAX    = 32'h00FF_FFFF;
    localparam logic [3:0] MOD_STEPS   = 4'd8;

endpackage

FILE: hdl/lrd_front.sv
// Front end: parses one text beat per cycle while the beat is accepted, keeps count, prefix and halt state.
// Pushes home, cursor, run and state-letter commands to the queue. Depends on lrd_pkg.
module lrd_front #(
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  lrd_pkg::t_in          i_item,
    output logic                  o_push,
    output lrd_pkg::t_cmd         o_cmd,
    output logic [COUNT_BITS-1:0] o_count
);
    import lrd_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] r_pend, n_pend;
    logic [7:0]            r_off, n_off;
    logic                  r_pfx, n_pfx;
    logic                  r_halt, n_halt;

    logic [COUNT_BITS+3:0] prod;
    logic [COUNT_BITS-1:0] cnt;
    logic [7:0]            ch;
    logic [15:0]           off_prod;

    assign ch       = i_item.ch;
    assign cnt      = (r_pend == '0) ? COUNT_BITS'(1) : r_pend;
    assign prod     = {4'd0, r_pend} * (COUNT_BITS+4)'(RADIX)
                    + (COUNT_BITS+4)'(ch - CH_ZERO);
    assign off_prod = PREFIX_STEP * (ch - CH_O);
    assign o_count  = cnt;

    always_comb begin
        n_pend    = r_pend;
        n_off     = r_off;
        n_pfx     = r_pfx;
        n_halt    = r_halt;
        o_push    = 1'b0;
        o_cmd     = '{kind: CMD_SKIP, val: '0};
        if (i_accept) begin
            if (i_item.op == OP_BEGIN) begin
                n_pend   = '0;
                n_off    = '0;
                n_pfx    = 1'b0;
                n_halt   = 1'b0;
                o_push   = 1'b1;
                o_cmd.kind = CMD_HOME;
            end else if (i_item.op == OP_END || (i_item.op == OP_CHAR && ch == CH_NUL)) begin
                n_pend = '0;
                n_off  = '0;
                n_pfx  = 1'b0;
                n_halt = 1'b0;
            end else if (i_item.op == OP_CHAR && !r_halt) begin
                if (r_pfx) begin
                    n_pend = '0;
                    n_off  = '0;
                    n_pfx  = 1'b0;
                    if (ch >= CH_A && ch <= CH_X) begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_LETTER;
                        o_cmd.val  = 9'(ch) - LETTER_BASE + 9'(r_off);
                    end else begin
                        n_halt = 1'b1;
                    end
                end else begin
                    case (ch) inside
                        [CH_ZERO:CH_NINE]: begin
                            n_pend = (prod[COUNT_BITS+3:COUNT_BITS] != 4'd0)
                                   ? COUNT_MAX : prod[COUNT_BITS-1:0];
                        end
                        [CH_P:CH_Y]: begin
                            n_pfx = 1'b1;
                            n_off = off_prod[7:0];
                        end
                        CH_DOLLAR: begin
                            n_pend     = '0;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_NEWLINE;
                        end
                        CH_DOT, CH_B: begin
                            n_pend     = '0;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_SKIP;
                        end
                        CH_O: begin
                            n_pend     = '0;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_RUN;
                        end
                        CH_NL, CH_TAB, CH_SP, CH_CR: begin
                            n_pend = '0;
                        end
                        [CH_A:CH_X]: begin
                            n_pend     = '0;
                            o_push     = 1'b1;
                            o_cmd.kind = CMD_LETTER;
                            o_cmd.val  = 9'(ch) - LETTER_BASE;
                        end
                        default: begin
                            n_pend = '0;
                            n_halt = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_off  <= '0;
            r_pfx  <= 1'b0;
            r_halt <= 1'b0;
        end else begin
            r_pend <= n_pend;
            r_off  <= n_off;
            r_pfx  <= n_pfx;
            r_halt <= n_halt;
        end
    end

endmodule

FILE: hdl/lrd_queue.sv
// Two-entry command queue between front end and back end.
// Generic width; depends on nothing.
module lrd_queue #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic [W-1:0] r_mem [2];
    logic         r_wr, r_rd;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: hdl/lrd_back.sv
// Back end: owns the cursor, reduces letter states and drives the result register.
// Depends on lrd_pkg.
module lrd_back #(
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrd_pkg::t_cfg         i_cfg,
    input  logic                  i_q_valid,
    input  lrd_pkg::t_cmd         i_cmd,
    input  logic [COUNT_BITS-1:0] i_count,
    output logic                  o_pop,
    output logic                  o_out_valid,
    output lrd_pkg::t_out         o_out,
    input  logic                  i_out_stall
);
    import lrd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MOD  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [31:0]           r_cx, n_cx;
    logic [31:0]           r_cy, n_cy;
    logic [COUNT_BITS-1:0] r_n, n_n;
    logic [8:0]            r_rem, n_rem;
    logic [3:0]            r_step, n_step;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out, n_out;

    logic        out_free;
    logic [31:0] in_n32, r_n32;
    logic [16:0] trial;

    function automatic logic [23:0] sat_run(input logic [31:0] n);
        sat_run = (n > RUN_MAX) ? RUN_MAX[23:0] : n[23:0];
    endfunction

    assign out_free    = !r_out_valid || !i_out_stall;
    assign in_n32      = 32'(i_count);
    assign r_n32       = 32'(r_n);
    assign trial       = 17'(i_cfg.state_modulus) << r_step;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state     = r_state;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_n         = r_n;
        n_rem       = r_rem;
        n_step      = r_step;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_cmd.kind)
                        CMD_HOME: begin
                            o_pop = 1'b1;
                            n_cx  = i_cfg.start_x;
                            n_cy  = i_cfg.start_y;
                        end
                        CMD_NEWLINE: begin
                            o_pop = 1'b1;
                            n_cx  = i_cfg.start_x;
                            n_cy  = r_cy + in_n32;
                        end
                        CMD_SKIP: begin
                            o_pop = 1'b1;
                            n_cx  = r_cx + in_n32;
                        end
                        CMD_RUN: begin
                            if (out_free) begin
                                o_pop                = 1'b1;
                                n_out_valid          = 1'b1;
                                n_out.cell_x         = i_cfg.origin_x + r_cx;
                                n_out.cell_y         = i_cfg.origin_y + r_cy;
                                n_out.run_length     = sat_run(in_n32);
                                n_out.cell_state     = 8'd1;
                                n_cx                 = r_cx + in_n32;
                            end
                        end
                        CMD_LETTER: begin
                            o_pop   = 1'b1;
                            n_n     = i_count;
                            n_rem   = i_cmd.val;
                            n_step  = MOD_STEPS;
                            n_state = (i_cfg.state_modulus == 9'd0) ? ST_DONE : ST_MOD;
                        end
                        default: begin
                            o_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (17'(r_rem) >= trial) begin
                    n_rem = 9'(17'(r_rem) - trial);
                end
                if (r_step == 4'd0) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step - 4'd1;
                end
            end
            ST_DONE: begin
                if (r_rem[7:0] == 8'd0) begin
                    n_cx    = r_cx + r_n32;
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.cell_x     = i_cfg.origin_x + r_cx;
                    n_out.cell_y     = i_cfg.origin_y + r_cy;
                    n_out.run_length = sat_run(r_n32);
                    n_out.cell_state = r_rem[7:0];
                    n_cx             = r_cx + r_n32;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cx        <= '0;
            r_cy        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_rem  <= n_rem;
        r_step <= n_step;
        r_out  <= n_out;
    end

endmodule

FILE: hdl/life_rle_pattern_decoder.sv
// Top level of the multistate pattern text decoder: config registers, front end,
// command queue and back end. Depends on lrd_pkg, lrd_front, lrd_queue, lrd_back.
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------
//   in       | input     | i_in_valid / o_in_stall | lrd_pkg::t_in
//   out      | output    | o_out_valid / i_out_stall | lrd_pkg::t_out
//   cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One text beat is parsed per cycle; the front end stalls only while the
// two-entry command queue is full. The back end executes cursor and 'o' commands
// as it pops them ('o' waits under a held result); a state letter passes issue,
// 9 restoring subtract steps and finish; a zero modulus skips the steps.
// Reset is synchronous; a result waits in the output register under stall
// while new beats keep entering the queue.
module life_rle_pattern_decoder #(
    parameter int COUNT_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  lrd_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output lrd_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import lrd_pkg::*;

    localparam int QW = CMD_BITS + COUNT_BITS;

    t_cfg                  r_cfg;
    logic                  accept;
    logic                  push, pop, q_full, q_valid;
    t_cmd                  f_cmd, b_cmd;
    logic [COUNT_BITS-1:0] f_count, b_count;
    logic [QW-1:0]         q_out;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !q_full;
    assign b_cmd       = t_cmd'(q_out[QW-1:COUNT_BITS]);
    assign b_count     = q_out[COUNT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{origin_x: '0, origin_y: '0, start_x: '0, start_y: '0,
                       state_modulus: MODULUS_RESET};
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_cfg.origin_x      <= i_cfg_data;
                CFG_ORIGIN_Y: r_cfg.origin_y      <= i_cfg_data;
                CFG_START_X:  r_cfg.start_x       <= i_cfg_data;
                CFG_START_Y:  r_cfg.start_y       <= i_cfg_data;
                CFG_MODULUS:  r_cfg.state_modulus <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    lrd_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_in),
        .o_push   (push),
        .o_cmd    (f_cmd),
        .o_count  (f_count)
    );

    lrd_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_count}),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    lrd_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_cmd       (b_cmd),
        .i_count     (b_count),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: hdl/lrd_checker.sv
// Port-level checks for the pattern text decoder, bound to the top level.
// Depends on lrd_pkg and life_rle_pattern_decoder.
module lrd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input lrd_pkg::t_out o_out
);
    import lrd_pkg::*;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped under stall");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result changed under stall");

    a_state_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.cell_state != 8'd0)
        else $error("run with zero state");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.run_length != 24'd0)
        else $error("run with zero length");

endmodule

bind life_rle_pattern_decoder lrd_checker u_lrd_checker (.*);

FILE: tb/sv/tb_lrd_run_check.sv
`timescale 1ns / 100ps
// Run checker for the pattern text decoder: tracks cursor, count and prefix state
// from the accepted text beats and compares every output run beat in order.
// Depends on lrd_pkg.
module tb_lrd_run_check #(
    parameter int COUNT_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  lrd_pkg::t_in  i_in,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  lrd_pkg::t_out i_out,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output int            o_fail_count,
    output int            o_pending
);
    import lrd_pkg::*;

    localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;

    logic [31:0] origin_x, origin_y, start_x, start_y;
    logic [8:0]  modulus;
    logic [31:0] cur_x, cur_y;
    logic [COUNT_BITS-1:0] run_count;
    logic [7:0]  pfx_off;
    logic        pfx_seen;
    logic        halted;
    t_out        runs_due[$];
    int          fails;

    initial begin
        fails = 0;
    end

    task automatic clear_token();
        run_count = '0;
        pfx_off = '0;
        pfx_seen = 1'b0;
    endtask

    task automatic push_run(input logic [31:0] n, input logic [7:0] st);
        t_out r;
        r.cell_x = origin_x + cur_x;
        r.cell_y = origin_y + cur_y;
        r.run_length = (n > RUN_MAX) ? RUN_MAX[23:0] : n[23:0];
        r.cell_state = st;
        runs_due.push_back(r);
        cur_x = cur_x + n;
    endtask

    task automatic place_letter(input logic [7:0] ch, input logic [7:0] dc,
                                input logic [31:0] n);
        logic [31:0] v;
        v = 32'(ch) - 32'(LETTER_BASE) + 32'(dc);
        if (modulus != 9'd0)
            v = v % 32'(modulus);
        if (v[7:0] == 8'd0)
            cur_x = cur_x + n;
        else
            push_run(n, v[7:0]);
    endtask

    task automatic decode_beat(input t_in b);
        logic [31:0] n;
        logic [7:0] dc;
        longint unsigned c;
        logic is_letter;
        is_letter = (b.ch >= CH_A) && (b.ch <= CH_X);
        if (b.op == OP_BEGIN) begin
            cur_x = start_x;
            cur_y = start_y;
            clear_token();
            halted = 1'b0;
            return;
        end
        if (b.op == OP_END || (b.op == OP_CHAR && b.ch == CH_NUL)) begin
            clear_token();
            halted = 1'b0;
            return;
        end
        if (b.op != OP_CHAR || halted)
            return;
        n = (run_count == '0) ? 32'd1 : 32'(run_count);
        if (pfx_seen) begin
            dc = pfx_off;
            clear_token();
            if (is_letter)
                place_letter(b.ch, dc, n);
            else
                halted = 1'b1;
            return;
        end
        if (b.ch >= CH_ZERO && b.ch <= CH_NINE) begin
            c = 64'(run_count) * 64'(RADIX) + 64'(b.ch - CH_ZERO);
            run_count = (c > COUNT_MAX) ? COUNT_MAX[COUNT_BITS-1:0] : c[COUNT_BITS-1:0];
            return;
        end
        if (b.ch >= CH_P && b.ch <= CH_Y) begin
            pfx_seen = 1'b1;
            pfx_off = PREFIX_STEP * (b.ch - CH_O);
            return;
        end
        clear_token();
        case (b.ch)
            CH_DOLLAR: begin
                cur_y = cur_y + n;
                cur_x = start_x;
            end
            CH_DOT, CH_B: begin
                cur_x = cur_x + n;
            end
            CH_O: begin
                push_run(n, 8'd1);
            end
            CH_NL, CH_TAB, CH_SP, CH_CR: begin
            end
            default: begin
                if (is_letter)
                    place_letter(b.ch, 8'd0, n);
                else
                    halted = 1'b1;
            end
        endcase
    endtask

    task automatic check_run(input t_out got);
        t_out want;
        if (runs_due.size() == 0) begin
            fails++;
            if (fails <= 10)
                $display("unexpected run: x=%h y=%h len=%0d state=%0d",
                         got.cell_x, got.cell_y, got.run_length, got.cell_state);
            return;
        end
        want = runs_due.pop_front();
        if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
            got.run_length !== want.run_length || got.cell_state !== want.cell_state) begin
            fails++;
            if (fails <= 10)
                $display({"run mismatch: expected x=%h y=%h len=%0d state=%0d, ",
                          "got x=%h y=%h len=%0d state=%0d"},
                         want.cell_x, want.cell_y, want.run_length, want.cell_state,
                         got.cell_x, got.cell_y, got.run_length, got.cell_state);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            CFG_ORIGIN_X: origin_x = data;
            CFG_ORIGIN_Y: origin_y = data;
            CFG_START_X:  start_x = data;
            CFG_START_Y:  start_y = data;
            CFG_MODULUS:  modulus = data[8:0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            origin_x = '0;
            origin_y = '0;
            start_x = '0;
            start_y = '0;
            modulus = MODULUS_RESET;
            cur_x = '0;
            cur_y = '0;
            clear_token();
            halted = 1'b0;
            runs_due.delete();
        end else begin
            if (i_cfg_valid === 1'b1 && i_cfg_ready === 1'b1)
                write_reg(i_cfg_index, i_cfg_data);
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0)
                check_run(i_out);
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0)
                decode_beat(i_in);
        end
        o_pending <= runs_due.size();
        o_fail_count <= fails;
    end

endmodule

FILE: tb/sv/tb_life_rle_pattern_decoder.sv
`timescale 1ns / 100ps
// Top of the decoder testbench: clock, reset, text and register stimulus, output stall.
// Depends on lrd_pkg, life_rle_pattern_decoder and tb_lrd_run_check.
module tb_life_rle_pattern_decoder;
    import lrd_pkg::*;

    localparam int COUNT_BITS    = 24;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int NUM_PHASES    = 6;
    localparam int PHASE_ITEMS   = 280;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    int fail_count;
    int pending;
    int items_sent;
    int cycles;
    bit in_idle_on;
    bit out_idle_on;
    bit hold_out;

    life_rle_pattern_decoder #(
        .COUNT_BITS(COUNT_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tb_lrd_run_check #(
        .COUNT_BITS(COUNT_BITS)
    ) run_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    task automatic send_beat(input t_op op, input logic [7:0] ch);
        t_in b;
        int gap;
        b.op = op;
        b.ch = ch;
        gap = in_idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= b;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        items_sent++;
    endtask

    task automatic send_token();
        int pick;
        int ndig;
        int k;
        int cmd;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            ndig = (pick < 3) ? $urandom_range(6, 10) : $urandom_range(0, 3);
            for (k = 0; k < ndig; k++)
                send_beat(OP_CHAR, CH_ZERO + 8'($urandom_range(0, 9)));
            cmd = $urandom_range(0, 9);
            if (cmd <= 2)
                send_beat(OP_CHAR, CH_O);
            else if (cmd == 3)
                send_beat(OP_CHAR, CH_B);
            else if (cmd == 4)
                send_beat(OP_CHAR, CH_DOT);
            else if (cmd == 5)
                send_beat(OP_CHAR, CH_DOLLAR);
            else if (cmd <= 7)
                send_beat(OP_CHAR, CH_A + 8'($urandom_range(0, 23)));
            else begin
                send_beat(OP_CHAR, CH_P + 8'($urandom_range(0, 9)));
                send_beat(OP_CHAR, CH_A + 8'($urandom_range(0, 23)));
            end
        end else if (pick < 80) begin
            case ($urandom_range(0, 3))
                0: send_beat(OP_CHAR, CH_NL);
                1: send_beat(OP_CHAR, CH_TAB);
                2: send_beat(OP_CHAR, CH_SP);
                default: send_beat(OP_CHAR, CH_CR);
            endcase
        end else if (pick < 85) begin
            send_beat(OP_BEGIN, 8'($urandom));
        end else if (pick < 88) begin
            if ($urandom_range(0, 1))
                send_beat(OP_END, 8'($urandom));
            else
                send_beat(OP_CHAR, CH_NUL);
        end else if (pick < 90) begin
            send_beat(OP_NOP, 8'($urandom));
        end else begin
            if (pick < 94)
                send_beat(OP_CHAR, CH_P + 8'($urandom_range(0, 9)));
            send_beat(OP_CHAR, 8'($urandom));
            if ($urandom_range(0, 1))
                send_beat(OP_END, 8'($urandom));
        end
    endtask

    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
    endtask

    // Output side: hold off per beat, with one long hold when requested.
    initial begin
        int gap;
        int held;
        i_out_stall <= 1'b0;
        forever begin
            if (hold_out) begin
                i_out_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_out = 1'b0;
            end
            gap = out_idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    initial begin
        int phase;
        int quota;
        logic [31:0] ox, oy, sx, sy;
        logic [8:0] md;
        items_sent = 0;
        in_idle_on = 1'b1;
        out_idle_on = 1'b1;
        hold_out = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_beat(OP_BEGIN, 8'h00);
        send_beat(OP_CHAR, CH_O);
        send_beat(OP_CHAR, CH_ZERO + 8'd3);
        send_beat(OP_CHAR, CH_O);
        send_beat(OP_CHAR, CH_ZERO);
        send_beat(OP_CHAR, CH_B);
        send_beat(OP_CHAR, CH_A);
        send_beat(OP_CHAR, CH_DOLLAR);
        repeat (8) send_beat(OP_CHAR, CH_NINE);
        send_beat(OP_CHAR, CH_O);
        send_beat(OP_CHAR, CH_P);
        send_beat(OP_CHAR, CH_A);
        send_beat(OP_CHAR, CH_Y);
        send_beat(OP_CHAR, CH_X);
        send_beat(OP_CHAR, CH_P);
        send_beat(OP_CHAR, CH_ZERO + 8'd5);
        send_beat(OP_CHAR, CH_O);
        send_beat(OP_CHAR, CH_NUL);
        send_beat(OP_CHAR, CH_SP);
        send_beat(OP_CHAR, CH_DOT);
        send_beat(OP_CHAR, 8'hFF);
        send_beat(OP_CHAR, CH_O);
        send_beat(OP_END, 8'h00);
        send_beat(OP_CHAR, CH_O);
        send_beat(OP_NOP, 8'h00);
        i_in_valid <= 1'b0;
        drain();

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    ox = '1; oy = '1; sx = '1; sy = '1;
                    md = 9'd256;
                end
                1: begin
                    ox = '0; oy = '0; sx = '0; sy = '0;
                    md = MODULUS_RESET;
                end
                3: begin
                    ox = 32'hFFFF_FFF0; oy = $urandom;
                    sx = 32'hFFFF_FFF8; sy = $urandom;
                    md = 9'd3;
                end
                default: begin
                    ox = $urandom; oy = $urandom; sx = $urandom; sy = $urandom;
                    md = 9'($urandom_range(2, 256));
                end
            endcase
            put_reg(CFG_ORIGIN_X, ox);
            put_reg(CFG_ORIGIN_Y, oy);
            put_reg(CFG_START_X, sx);
            put_reg(CFG_START_Y, sy);
            put_reg(CFG_MODULUS, 32'(md));
            i_cfg_valid <= 1'b0;
            in_idle_on = (phase != 1);
            out_idle_on = (phase != 1);
            send_beat(OP_BEGIN, 8'($urandom));
            if (phase == 2)
                hold_out = 1'b1;
            quota = items_sent + PHASE_ITEMS;
            while (items_sent < quota)
                send_token();
            i_in_valid <= 1'b0;
            drain();
        end

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
